// ===== rtl/core/hlik_pkg.sv =====
// shared constants and types of the hexapod leg inverse kinematics block
package hlik_pkg;

    localparam int LEG_COUNT   = 6;
    localparam int LEG_W       = $clog2(LEG_COUNT);
    localparam int ROW_COUNT   = LEG_COUNT * 2;
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int ANCHOR_W    = 96;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        MODE_WRITE = 1'b0,
        MODE_POSE  = 1'b1
    } mode_t;

    typedef struct packed {
        logic               is_pose;
        logic [ROW_W-1:0]   row;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] qw;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
    } hlik_cmd_t;

endpackage

// ===== rtl/core/hlik_ram.sv =====
// generic single-port-write ram with registered read
module hlik_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 12
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/hlik_front.sv =====
// front end: takes requests, drops out-of-range anchor writes, builds commands
module hlik_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [2:0]            s_leg,
    input  logic                  s_anchor_set,
    input  logic signed [31:0]    s_px,
    input  logic signed [31:0]    s_py,
    input  logic signed [31:0]    s_pz,
    input  logic signed [31:0]    s_qw,
    input  logic signed [31:0]    s_qx,
    input  logic signed [31:0]    s_qy,
    input  logic signed [31:0]    s_qz,
    input  logic                  q_full,
    output logic                  push,
    output hlik_pkg::hlik_cmd_t   cmd
);

    logic is_pose;
    logic leg_ok;

    assign is_pose = (hlik_pkg::mode_t'(s_mode) == hlik_pkg::MODE_POSE);
    assign leg_ok  = (32'(s_leg) < 32'(hlik_pkg::LEG_COUNT));
    assign s_ready = !q_full;
    // a write to a leg that does not exist is taken and forgotten
    assign push    = s_valid && !q_full && (is_pose || leg_ok);

    always_comb begin
        cmd.is_pose = is_pose;
        cmd.row     = hlik_pkg::ROW_W'({s_leg, s_anchor_set});
        cmd.px      = s_px;
        cmd.py      = s_py;
        cmd.pz      = s_pz;
        cmd.qw      = s_qw;
        cmd.qx      = s_qx;
        cmd.qy      = s_qy;
        cmd.qz      = s_qz;
    end

endmodule

// ===== rtl/core/hlik_queue.sv =====
// short command queue between front and back
module hlik_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hlik_pkg::hlik_cmd_t push_cmd,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output hlik_pkg::hlik_cmd_t head
);

    hlik_pkg::hlik_cmd_t              entry_reg [hlik_pkg::QUEUE_DEPTH];
    logic [hlik_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [hlik_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [hlik_pkg::QCNT_W-1:0]      count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (count_reg == hlik_pkg::QCNT_W'(hlik_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    function automatic logic [hlik_pkg::QPTR_W-1:0] bump(input logic [hlik_pkg::QPTR_W-1:0] p);
        return (p == hlik_pkg::QPTR_W'(hlik_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/hlik_back.sv =====
// back end: anchor store, rotation, leg vectors, square root and divide sequencer
module hlik_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  hlik_pkg::hlik_cmd_t q_head,
    output logic                q_pop,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [2:0]          m_leg_index,
    output logic [31:0]         m_leg_length,
    output logic signed [31:0]  m_dir_x,
    output logic signed [31:0]  m_dir_y,
    output logic signed [31:0]  m_dir_z,
    output logic                m_degenerate,
    output logic                m_last_leg
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_QMUL = 14'b00000000000010,
        S_RMAT = 14'b00000000000100,
        S_RDP  = 14'b00000000001000,
        S_RDB  = 14'b00000000010000,
        S_MAT  = 14'b00000000100000,
        S_MAG  = 14'b00000001000000,
        S_SCL  = 14'b00000010000000,
        S_SQ   = 14'b00000100000000,
        S_SQRT = 14'b00001000000000,
        S_RND  = 14'b00010000000000,
        S_DVI  = 14'b00100000000000,
        S_DIV  = 14'b01000000000000,
        S_EMIT = 14'b10000000000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [4:0]                      step_reg;
    logic [hlik_pkg::LEG_W-1:0]      leg_reg;
    logic signed [31:0]              pos_reg  [3];
    logic signed [31:0]              quat_reg [4];
    logic signed [33:0]              qp_reg   [9];
    logic signed [31:0]              rot_reg  [9];
    logic signed [31:0]              anc_reg  [3];
    logic signed [39:0]              acc_reg  [3];
    logic [39:0]                     mag_reg  [3];
    logic [2:0]                      neg_reg;
    logic [30:0]                     m_reg    [3];
    logic [3:0]                      k_reg;
    logic [63:0]                     sum_reg;
    logic [63:0]                     rem_reg;
    logic [63:0]                     root_reg;
    logic [32:0]                     n_reg;
    logic [31:0]                     len_reg;
    logic                            degen_reg;
    logic [1:0]                      dj_reg;
    logic [61:0]                     div_rem_reg;
    logic [30:0]                     quot_reg;
    logic signed [31:0]              dir_reg  [3];
    logic signed [63:0]              mul_p_reg;
    logic [hlik_pkg::ROW_COUNT-1:0]  row_valid_reg;
    logic                            rd_ok_reg;
    logic                            m_valid_reg;
    logic [2:0]                      out_leg_reg;
    logic [31:0]                     out_len_reg;
    logic signed [31:0]              out_dir_reg [3];
    logic                            out_degen_reg;
    logic                            out_last_reg;

    logic signed [31:0]              mul_a, mul_b;
    logic [3:0]                      cons_idx;
    logic                            ram_we;
    logic [hlik_pkg::ROW_W-1:0]      ram_raddr;
    logic [hlik_pkg::ANCHOR_W-1:0]   ram_rdata;
    logic signed [31:0]              base_val [3];
    logic [63:0]                     sq_bit, sq_trial, sum_add;
    logic [39:0]                     or_mag;
    logic [3:0]                      k_calc;
    logic [32:0]                     n_calc;
    logic [41:0]                     len_wide;
    logic [4:0]                      div_sh;
    logic [62:0]                     div_sub;
    logic                            div_take;
    logic [30:0]                     quot_fin;
    logic                            emit_go;
    logic                            last_leg;

    function automatic logic [1:0] quat_a(input logic [3:0] i);
        unique case (i)
            4'd0, 4'd3, 4'd4, 4'd6: return 2'd1;
            4'd1, 4'd5, 4'd7:       return 2'd2;
            4'd2, 4'd8:             return 2'd3;
            default:                return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] quat_b(input logic [3:0] i);
        unique case (i)
            4'd0:                   return 2'd1;
            4'd1, 4'd3:             return 2'd2;
            4'd2, 4'd4, 4'd5:       return 2'd3;
            default:                return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] row_of(input logic [3:0] i);
        unique case (i)
            4'd0, 4'd1, 4'd2: return 2'd0;
            4'd3, 4'd4, 4'd5: return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] col_of(input logic [3:0] i);
        unique case (i)
            4'd0, 4'd3, 4'd6: return 2'd0;
            4'd1, 4'd4, 4'd7: return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    function automatic logic signed [33:0] round30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd536870912;
        return t[63:30];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'h7fffffff;
        end else if (v < -38'sd2147483648) begin
            return 32'h80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    hlik_ram #(
        .WIDTH (hlik_pkg::ANCHOR_W),
        .DEPTH (hlik_pkg::ROW_COUNT)
    ) u_anchor_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (q_head.row),
        .wr_data ({q_head.pz, q_head.py, q_head.px}),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign ram_we    = q_pop && !q_head.is_pose;
    assign ram_raddr = (state_reg == S_RDP) ? {leg_reg, 1'b0} : {leg_reg, 1'b1};
    assign cons_idx  = 4'(step_reg - 5'd1);
    assign last_leg  = (leg_reg == hlik_pkg::LEG_W'(hlik_pkg::LEG_COUNT - 1));
    assign emit_go   = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            base_val[c] = rd_ok_reg ? $signed(ram_rdata[32*c +: 32]) : 32'sd0;
        end
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_QMUL: begin
                if (step_reg < 5'd9) begin
                    mul_a = quat_reg[quat_a(step_reg[3:0])];
                    mul_b = quat_reg[quat_b(step_reg[3:0])];
                end
            end
            S_MAT: begin
                if (step_reg < 5'd9) begin
                    mul_a = rot_reg[step_reg[3:0]];
                    mul_b = anc_reg[col_of(step_reg[3:0])];
                end
            end
            S_SQ: begin
                if (step_reg < 5'd3) begin
                    mul_a = {1'b0, m_reg[step_reg[1:0]]};
                    mul_b = {1'b0, m_reg[step_reg[1:0]]};
                end
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign sum_add = sum_reg + $unsigned(mul_p_reg);

    // smallest scale that brings all three magnitudes below 2^31
    always_comb begin
        or_mag = mag_reg[0] | mag_reg[1] | mag_reg[2];
        k_calc = 4'd9;
        for (int kk = 9; kk >= 0; kk--) begin
            if ((or_mag >> (31 + kk)) == '0) begin
                k_calc = 4'(kk);
            end
        end
    end

    assign sq_bit   = 64'(1) << {5'd31 - step_reg, 1'b0};
    assign sq_trial = root_reg + sq_bit;
    assign n_calc   = root_reg[32:0] + 33'(rem_reg > root_reg);
    assign len_wide = 42'(n_calc) << k_reg;

    assign div_sh   = 5'd30 - step_reg;
    assign div_sub  = 63'(n_reg) << div_sh;
    assign div_take = ({1'b0, div_rem_reg} >= div_sub);
    assign quot_fin = div_take ? (quot_reg | (31'(1) << div_sh)) : quot_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty && q_head.is_pose) state_next = S_QMUL;
            end
            S_QMUL: begin
                if (step_reg == 5'd9) state_next = S_RMAT;
            end
            S_RMAT: state_next = S_RDP;
            S_RDP:  state_next = S_RDB;
            S_RDB:  state_next = S_MAT;
            S_MAT: begin
                if (step_reg == 5'd9) state_next = S_MAG;
            end
            S_MAG:  state_next = S_SCL;
            S_SCL:  state_next = S_SQ;
            S_SQ: begin
                if (step_reg == 5'd3) state_next = S_SQRT;
            end
            S_SQRT: begin
                if (step_reg == 5'd31) state_next = S_RND;
            end
            S_RND: begin
                state_next = (n_calc == '0) ? S_EMIT : S_DVI;
            end
            S_DVI:  state_next = S_DIV;
            S_DIV: begin
                if (step_reg == 5'd30) state_next = (dj_reg == 2'd2) ? S_EMIT : S_DVI;
            end
            S_EMIT: begin
                if (emit_go) state_next = last_leg ? S_IDLE : S_RDP;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? 5'd0 : step_reg + 5'd1;
            if (ram_we) begin
                row_valid_reg[q_head.row] <= 1'b1;
            end
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    logic signed [37:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
    localparam logic signed [37:0] ONE_Q30 = 38'sd1073741824;

    always_comb begin
        xx = 38'(qp_reg[0]);
        yy = 38'(qp_reg[1]);
        zz = 38'(qp_reg[2]);
        xy = 38'(qp_reg[3]);
        xz = 38'(qp_reg[4]);
        yz = 38'(qp_reg[5]);
        xw = 38'(qp_reg[6]);
        yw = 38'(qp_reg[7]);
        zw = 38'(qp_reg[8]);
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= $signed({{32{mul_a[31]}}, mul_a}) * $signed({{32{mul_b[31]}}, mul_b});
        rd_ok_reg <= row_valid_reg[ram_raddr];
        unique case (state_reg)
            S_IDLE: begin
                if (q_pop && q_head.is_pose) begin
                    pos_reg[0]  <= q_head.px;
                    pos_reg[1]  <= q_head.py;
                    pos_reg[2]  <= q_head.pz;
                    quat_reg[0] <= q_head.qw;
                    quat_reg[1] <= q_head.qx;
                    quat_reg[2] <= q_head.qy;
                    quat_reg[3] <= q_head.qz;
                end
            end
            S_QMUL: begin
                if (step_reg != 5'd0) begin
                    qp_reg[cons_idx] <= round30(mul_p_reg);
                end
            end
            S_RMAT: begin
                rot_reg[0] <= sat32(ONE_Q30 - ((yy + zz) <<< 1));
                rot_reg[1] <= sat32((xy - zw) <<< 1);
                rot_reg[2] <= sat32((xz + yw) <<< 1);
                rot_reg[3] <= sat32((xy + zw) <<< 1);
                rot_reg[4] <= sat32(ONE_Q30 - ((xx + zz) <<< 1));
                rot_reg[5] <= sat32((yz - xw) <<< 1);
                rot_reg[6] <= sat32((xz - yw) <<< 1);
                rot_reg[7] <= sat32((yz + xw) <<< 1);
                rot_reg[8] <= sat32(ONE_Q30 - ((xx + yy) <<< 1));
                leg_reg    <= '0;
            end
            S_RDB: begin
                for (int c = 0; c < 3; c++) begin
                    anc_reg[c] <= base_val[c];
                end
            end
            S_MAT: begin
                if (step_reg == 5'd0) begin
                    for (int j = 0; j < 3; j++) begin
                        acc_reg[j] <= 40'(pos_reg[j]) - 40'(base_val[j]);
                    end
                end else begin
                    acc_reg[row_of(cons_idx)] <= acc_reg[row_of(cons_idx)]
                                                 + 40'(round30(mul_p_reg));
                end
            end
            S_MAG: begin
                for (int j = 0; j < 3; j++) begin
                    neg_reg[j] <= acc_reg[j][39];
                    mag_reg[j] <= acc_reg[j][39] ? $unsigned(-acc_reg[j])
                                                 : $unsigned(acc_reg[j]);
                end
            end
            S_SCL: begin
                k_reg   <= k_calc;
                sum_reg <= '0;
                for (int j = 0; j < 3; j++) begin
                    m_reg[j] <= 31'(mag_reg[j] >> k_calc);
                end
            end
            S_SQ: begin
                if (step_reg != 5'd0) begin
                    sum_reg <= sum_add;
                end
                if (step_reg == 5'd3) begin
                    rem_reg  <= sum_add;
                    root_reg <= '0;
                end
            end
            S_SQRT: begin
                if (rem_reg >= sq_trial) begin
                    rem_reg  <= rem_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + sq_bit;
                end else begin
                    root_reg <= root_reg >> 1;
                end
            end
            S_RND: begin
                // a zero root shifts to a zero length
                n_reg     <= n_calc;
                len_reg   <= (len_wide[41:32] != '0) ? 32'hffffffff : len_wide[31:0];
                degen_reg <= (n_calc == '0);
                dj_reg    <= 2'd0;
                if (n_calc == '0) begin
                    for (int j = 0; j < 3; j++) begin
                        dir_reg[j] <= '0;
                    end
                end
            end
            S_DVI: begin
                div_rem_reg <= 62'({m_reg[dj_reg], 30'd0}) + 62'(n_reg >> 1);
                quot_reg    <= '0;
            end
            S_DIV: begin
                if (div_take) begin
                    div_rem_reg <= div_rem_reg - div_sub[61:0];
                end
                quot_reg <= quot_fin;
                if (step_reg == 5'd30) begin
                    dir_reg[dj_reg] <= neg_reg[dj_reg] ? -$signed(32'(quot_fin))
                                                       : $signed(32'(quot_fin));
                    dj_reg <= dj_reg + 2'd1;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    out_leg_reg    <= 3'(leg_reg);
                    out_len_reg    <= len_reg;
                    out_degen_reg  <= degen_reg;
                    out_last_reg   <= last_leg;
                    for (int j = 0; j < 3; j++) begin
                        out_dir_reg[j] <= dir_reg[j];
                    end
                    leg_reg <= leg_reg + 1'b1;
                end
            end
            default: begin
                dj_reg <= dj_reg;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_leg_index  = out_leg_reg;
    assign m_leg_length = out_len_reg;
    assign m_dir_x      = out_dir_reg[0];
    assign m_dir_y      = out_dir_reg[1];
    assign m_dir_z      = out_dir_reg[2];
    assign m_degenerate = out_degen_reg;
    assign m_last_leg   = out_last_reg;

endmodule

// ===== rtl/core/hexapod_leg_inverse_kinematics_top.sv =====
// top level of the hexapod leg inverse kinematics block
//
//  channel | direction | handshake          | carries
//  s_      | in        | s_valid / s_ready  | anchor write or pose request
//  m_      | out       | m_valid / m_ready  | one leg result per request leg
//
// an anchor write leaves the queue while the back end stays idle
// a pose is solved leg by leg, its pace set by the single shared 32x32 multiplier,
// the 32-step bit-serial square root and three 31-step restoring divides per leg;
// a zero leg skips the divides
// reset clears the anchor store valid bits, so unwritten anchors read as zero
// the two-entry queue keeps taking requests while the back end is busy, until it is full
// a stalled result holds in the output register; the back end waits on it
module hexapod_leg_inverse_kinematics_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [2:0]         s_leg,
    input  logic               s_anchor_set,
    input  logic signed [31:0] s_px,
    input  logic signed [31:0] s_py,
    input  logic signed [31:0] s_pz,
    input  logic signed [31:0] s_qw,
    input  logic signed [31:0] s_qx,
    input  logic signed [31:0] s_qy,
    input  logic signed [31:0] s_qz,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_leg_index,
    output logic [31:0]        m_leg_length,
    output logic signed [31:0] m_dir_x,
    output logic signed [31:0] m_dir_y,
    output logic signed [31:0] m_dir_z,
    output logic               m_degenerate,
    output logic               m_last_leg
);

    // front to queue
    logic                push;
    hlik_pkg::hlik_cmd_t push_cmd;
    logic                q_full;
    // queue to back
    logic                q_empty;
    logic                q_pop;
    hlik_pkg::hlik_cmd_t q_head;

    // classify requests: poses and in-range anchor writes go on
    hlik_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_leg        (s_leg),
        .s_anchor_set (s_anchor_set),
        .s_px         (s_px),
        .s_py         (s_py),
        .s_pz         (s_pz),
        .s_qw         (s_qw),
        .s_qx         (s_qx),
        .s_qy         (s_qy),
        .s_qz         (s_qz),
        .q_full       (q_full),
        .push         (push),
        .cmd          (push_cmd)
    );

    // decouples the request side from the long pose solve
    hlik_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // anchor store, rotation matrix, per-leg length and direction
    hlik_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_leg_index  (m_leg_index),
        .m_leg_length (m_leg_length),
        .m_dir_x      (m_dir_x),
        .m_dir_y      (m_dir_y),
        .m_dir_z      (m_dir_z),
        .m_degenerate (m_degenerate),
        .m_last_leg   (m_last_leg)
    );

endmodule

// ===== rtl/core/hlik_checker.sv =====
// port-level checks on the leg result channel, bound to the top level
module hlik_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_leg_index,
    input logic [31:0]        m_leg_length,
    input logic signed [31:0] m_dir_x,
    input logic signed [31:0] m_dir_y,
    input logic signed [31:0] m_dir_z,
    input logic               m_degenerate,
    input logic               m_last_leg
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_leg_index) && $stable(m_leg_length))
        else $error("result changed while stalled");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_leg_length == 32'd0 && m_dir_x == 32'sd0
                                    && m_dir_y == 32'sd0 && m_dir_z == 32'sd0)
        else $error("zero leg with nonzero fields");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |-> m_leg_length != 32'd0)
        else $error("zero length without zero-leg flag");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_leg |-> m_leg_index == 3'(hlik_pkg::LEG_COUNT - 1))
        else $error("last flag on wrong leg");

endmodule

bind hexapod_leg_inverse_kinematics_top hlik_checker u_hlik_checker (.*);

// ===== dv/hexapod_leg_inverse_kinematics_top_tb.sv =====
// self-checking testbench of the hexapod leg inverse kinematics block
module hexapod_leg_inverse_kinematics_top_tb;

    localparam int RANDOM_REQS = 187;
    localparam int DRAIN_CYCLES = 2000;
    localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;  // 1.0 in Q2.30
    localparam logic signed [31:0] Q_HALF = 32'sh2000_0000; // 0.5 in Q2.30
    localparam logic signed [31:0] Q_R2 = 32'sh2D41_3CCD;   // 0.7071 in Q2.30
    localparam logic signed [31:0] P_ONE = 32'sh0001_0000;  // 1.0 in Q16.16
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // one request on the s_ channel
    typedef struct {
        hlik_pkg::mode_t    mode;
        logic [2:0]         leg;
        logic               anchor_set;
        logic signed [31:0] px, py, pz;
        logic signed [31:0] qw, qx, qy, qz;
    } leg_req_t;

    // one leg result on the m_ channel
    typedef struct {
        logic [2:0]         leg_index;
        logic [31:0]        leg_length;
        logic signed [31:0] dir_x, dir_y, dir_z;
        logic               degenerate;
        logic               last_leg;
    } leg_result_t;

    // directed row: all_degenerate means every leg is known to come back zero
    typedef struct {
        leg_req_t req;
        logic     all_degenerate;
    } directed_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [2:0]         s_leg;
    logic               s_anchor_set;
    logic signed [31:0] s_px, s_py, s_pz;
    logic signed [31:0] s_qw, s_qx, s_qy, s_qz;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_leg_index;
    logic [31:0]        m_leg_length;
    logic signed [31:0] m_dir_x, m_dir_y, m_dir_z;
    logic               m_degenerate;
    logic               m_last_leg;

    // our own copy of the anchor store: [leg][platform/base][x,y,z]
    logic signed [31:0] anchor_mem [hlik_pkg::LEG_COUNT][2][3];
    leg_result_t        pending_legs[$];
    directed_row_t      directed_rows[$];
    int                 mismatch_count = 0;
    int                 send_idle_pct = 28;
    int                 recv_stall_pct = 78;

    hexapod_leg_inverse_kinematics_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_leg        (s_leg),
        .s_anchor_set (s_anchor_set),
        .s_px         (s_px),
        .s_py         (s_py),
        .s_pz         (s_pz),
        .s_qw         (s_qw),
        .s_qx         (s_qx),
        .s_qy         (s_qy),
        .s_qz         (s_qz),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_leg_index  (m_leg_index),
        .m_leg_length (m_leg_length),
        .m_dir_x      (m_dir_x),
        .m_dir_y      (m_dir_y),
        .m_dir_z      (m_dir_z),
        .m_degenerate (m_degenerate),
        .m_last_leg   (m_last_leg)
    );

    always #4 aclk = ~aclk;

    // q2.30 product rounded half up
    function automatic longint rnd30(longint v);
        return (v + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // bit-pair integer square root, floor
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // rotation matrix from the quaternion, then length and direction of every leg
    function automatic void solve_legs(leg_req_t r);
        longint qw, qx, qy, qz;
        longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
        longint rot [3][3];
        longint pos [3];
        longint lv [3];
        longint acc;
        longint unsigned mag [3];
        longint unsigned m, sum, n, len, qv;
        int unsigned k;
        leg_result_t res;
        qw = r.qw; qx = r.qx; qy = r.qy; qz = r.qz;
        pos[0] = r.px; pos[1] = r.py; pos[2] = r.pz;
        xx = rnd30(qx * qx); yy = rnd30(qy * qy); zz = rnd30(qz * qz);
        xy = rnd30(qx * qy); xz = rnd30(qx * qz); yz = rnd30(qy * qz);
        xw = rnd30(qx * qw); yw = rnd30(qy * qw); zw = rnd30(qz * qw);
        rot[0][0] = clamp32(Q_ONE - 2 * (yy + zz));
        rot[0][1] = clamp32(2 * (xy - zw));
        rot[0][2] = clamp32(2 * (xz + yw));
        rot[1][0] = clamp32(2 * (xy + zw));
        rot[1][1] = clamp32(Q_ONE - 2 * (xx + zz));
        rot[1][2] = clamp32(2 * (yz - xw));
        rot[2][0] = clamp32(2 * (xz - yw));
        rot[2][1] = clamp32(2 * (yz + xw));
        rot[2][2] = clamp32(Q_ONE - 2 * (xx + yy));
        for (int i = 0; i < hlik_pkg::LEG_COUNT; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int c = 0; c < 3; c++)
                    acc += rnd30(rot[j][c] * longint'(anchor_mem[i][0][c]));
                lv[j] = pos[j] + acc - longint'(anchor_mem[i][1][j]);
                mag[j] = (lv[j] < 0) ? longint'(-lv[j]) : longint'(lv[j]);
            end
            k = 0;
            while (k < 40 && ((mag[0] >> k) >= 64'h8000_0000 ||
                              (mag[1] >> k) >= 64'h8000_0000 ||
                              (mag[2] >> k) >= 64'h8000_0000))
                k++;
            sum = 0;
            for (int j = 0; j < 3; j++) begin
                m = mag[j] >> k;
                sum += m * m;
            end
            n = floor_sqrt(sum);
            if (sum - n * n > n) n++;
            res.leg_index = i[2:0];
            res.last_leg = (i == hlik_pkg::LEG_COUNT - 1);
            res.leg_length = '0;
            res.dir_x = '0; res.dir_y = '0; res.dir_z = '0;
            res.degenerate = (n == 0);
            if (n != 0) begin
                len = n << k;
                res.leg_length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
                for (int j = 0; j < 3; j++) begin
                    m = mag[j] >> k;
                    qv = ((m << 30) + (n >> 1)) / n;
                    if (qv > 64'h7FFF_FFFF) qv = 64'h7FFF_FFFF;
                    if (lv[j] < 0) qv = -qv;
                    case (j)
                        0: res.dir_x = qv[31:0];
                        1: res.dir_y = qv[31:0];
                        default: res.dir_z = qv[31:0];
                    endcase
                end
            end
            pending_legs.push_back(res);
        end
    endfunction

    function automatic leg_req_t make_req(hlik_pkg::mode_t md, logic [2:0] lg, logic st,
                                          logic signed [31:0] x, y, z,
                                          logic signed [31:0] w, a, b, c);
        leg_req_t r;
        r.mode = md; r.leg = lg; r.anchor_set = st;
        r.px = x; r.py = y; r.pz = z;
        r.qw = w; r.qx = a; r.qy = b; r.qz = c;
        return r;
    endfunction

    function automatic void add_row(leg_req_t r, logic zero_legs);
        directed_row_t d;
        d.req = r;
        d.all_degenerate = zero_legs;
        directed_rows.push_back(d);
    endfunction

    // a request becomes visible to the model the moment it is accepted
    function automatic void on_accept(directed_row_t d);
        leg_result_t z;
        if (d.req.mode == hlik_pkg::MODE_WRITE) begin
            if (d.req.leg < hlik_pkg::LEG_COUNT) begin
                anchor_mem[d.req.leg][d.req.anchor_set][0] = d.req.px;
                anchor_mem[d.req.leg][d.req.anchor_set][1] = d.req.py;
                anchor_mem[d.req.leg][d.req.anchor_set][2] = d.req.pz;
            end
        end else if (d.all_degenerate) begin
            for (int i = 0; i < hlik_pkg::LEG_COUNT; i++) begin
                z.leg_index = i[2:0];
                z.leg_length = '0;
                z.dir_x = '0; z.dir_y = '0; z.dir_z = '0;
                z.degenerate = 1'b1;
                z.last_leg = (i == hlik_pkg::LEG_COUNT - 1);
                pending_legs.push_back(z);
            end
        end else begin
            solve_legs(d.req);
        end
    endfunction

    // small anchor or position coordinate, within about +-8.0, now and then any value
    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(99) < 15) return $urandom;
        return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic leg_req_t rand_req();
        leg_req_t r;
        logic signed [31:0] qs [4];
        int pick;
        r.mode = ($urandom_range(99) < 40) ? hlik_pkg::MODE_WRITE : hlik_pkg::MODE_POSE;
        r.leg = 3'($urandom_range(0, 7));
        r.anchor_set = 1'($urandom_range(0, 1));
        r.px = rand_coord(); r.py = rand_coord(); r.pz = rand_coord();
        pick = $urandom_range(99);
        if (pick < 55) begin
            // a well-formed rotation: identity, quarter or half turn about an axis, or a diagonal
            qs = '{Q_ONE, 0, 0, 0};
            case ($urandom_range(0, 3))
                0: qs = '{Q_ONE, 0, 0, 0};
                1: begin
                    qs = '{Q_R2, 0, 0, 0};
                    qs[$urandom_range(1, 3)] = Q_R2;
                end
                2: begin
                    qs = '{0, 0, 0, 0};
                    qs[$urandom_range(1, 3)] = Q_ONE;
                end
                default: qs = '{Q_HALF, Q_HALF, Q_HALF, Q_HALF};
            endcase
            for (int i = 0; i < 4; i++)
                if ($urandom_range(0, 1)) qs[i] = -qs[i];
        end else if (pick < 85) begin
            for (int i = 0; i < 4; i++)
                qs[i] = $signed($urandom_range(0, 32'h8000_0000)) - Q_ONE;
        end else begin
            for (int i = 0; i < 4; i++) qs[i] = $urandom;
        end
        r.qw = qs[0]; r.qx = qs[1]; r.qy = qs[2]; r.qz = qs[3];
        return r;
    endfunction

    // one request: optional random idle, then hold valid until the handshake
    task automatic send_req(directed_row_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= d.req.mode;
        s_leg        <= d.req.leg;
        s_anchor_set <= d.req.anchor_set;
        s_px <= d.req.px; s_py <= d.req.py; s_pz <= d.req.pz;
        s_qw <= d.req.qw; s_qx <= d.req.qx; s_qy <= d.req.qy; s_qz <= d.req.qz;
        do @(posedge aclk); while (!s_ready);
        on_accept(d);
    endtask

    // result side: check on handshake, then pick next cycle's ready
    always @(posedge aclk) begin
        leg_result_t exp_leg;
        if (aresetn && m_valid && m_ready) begin
            if (pending_legs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected leg result: leg %0d length %h",
                             m_leg_index, m_leg_length);
            end else begin
                exp_leg = pending_legs.pop_front();
                if (m_leg_index !== exp_leg.leg_index || m_leg_length !== exp_leg.leg_length ||
                    m_dir_x !== exp_leg.dir_x || m_dir_y !== exp_leg.dir_y ||
                    m_dir_z !== exp_leg.dir_z || m_degenerate !== exp_leg.degenerate ||
                    m_last_leg !== exp_leg.last_leg) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("leg mismatch exp: leg %0d len %h dir %h %h %h deg %b last %b",
                                 exp_leg.leg_index, exp_leg.leg_length, exp_leg.dir_x,
                                 exp_leg.dir_y, exp_leg.dir_z, exp_leg.degenerate,
                                 exp_leg.last_leg);
                        $display("               got: leg %0d len %h dir %h %h %h deg %b last %b",
                                 m_leg_index, m_leg_length, m_dir_x, m_dir_y, m_dir_z,
                                 m_degenerate, m_last_leg);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        directed_row_t d;
        int sent;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = hlik_pkg::MODE_WRITE;
        s_leg = '0;
        s_anchor_set = 1'b0;
        s_px = '0; s_py = '0; s_pz = '0;
        s_qw = '0; s_qx = '0; s_qy = '0; s_qz = '0;
        m_ready = 1'b0;
        for (int i = 0; i < hlik_pkg::LEG_COUNT; i++)
            for (int s = 0; s < 2; s++)
                for (int c = 0; c < 3; c++)
                    anchor_mem[i][s][c] = '0;

        // empty store: every leg is a zero leg, whatever the rotation
        add_row(make_req(hlik_pkg::MODE_POSE, 0, 0, 0, 0, 0, Q_ONE, 0, 0, 0), 1'b1);
        add_row(make_req(hlik_pkg::MODE_POSE, 7, 1, 0, 0, 0,
                         S32_MIN, S32_MIN, S32_MIN, S32_MIN), 1'b1);
        add_row(make_req(hlik_pkg::MODE_POSE, 0, 0, 0, 0, 0,
                         S32_MAX, S32_MAX, S32_MAX, S32_MAX), 1'b1);
        // anchors on a line for legs 1 to 5, base wider than platform; leg 0 left at zero
        for (int i = 1; i < hlik_pkg::LEG_COUNT; i++) begin
            add_row(make_req(hlik_pkg::MODE_WRITE, 3'(i), 0, i * P_ONE, -i * P_ONE / 2, 0,
                             0, 0, 0, 0), 1'b0);
            add_row(make_req(hlik_pkg::MODE_WRITE, 3'(i), 1, 2 * i * P_ONE, i * P_ONE, -P_ONE,
                             0, 0, 0, 0), 1'b0);
        end
        // out-of-range legs are dropped
        add_row(make_req(hlik_pkg::MODE_WRITE, 6, 0, S32_MAX, S32_MAX, S32_MAX,
                         0, 0, 0, 0), 1'b0);
        add_row(make_req(hlik_pkg::MODE_WRITE, 7, 1, S32_MIN, S32_MIN, S32_MIN,
                         0, 0, 0, 0), 1'b0);
        // identity at the origin: leg 0 stays a zero leg
        add_row(make_req(hlik_pkg::MODE_POSE, 0, 0, 0, 0, 0, Q_ONE, 0, 0, 0), 1'b0);
        add_row(make_req(hlik_pkg::MODE_POSE, 0, 0, 0, 0, 3 * P_ONE, Q_R2, 0, 0, Q_R2), 1'b0);
        // extreme anchors and positions: length saturates
        add_row(make_req(hlik_pkg::MODE_WRITE, 5, 0, S32_MAX, S32_MAX, S32_MAX,
                         0, 0, 0, 0), 1'b0);
        add_row(make_req(hlik_pkg::MODE_WRITE, 5, 1, S32_MIN, S32_MIN, S32_MIN,
                         0, 0, 0, 0), 1'b0);
        add_row(make_req(hlik_pkg::MODE_POSE, 0, 0, S32_MAX, S32_MAX, S32_MAX,
                         Q_ONE, 0, 0, 0), 1'b0);
        add_row(make_req(hlik_pkg::MODE_POSE, 0, 0, S32_MIN, S32_MIN, S32_MIN,
                         -Q_ONE, 0, 0, 0), 1'b0);
        // non-unit quaternions with saturated matrix entries
        add_row(make_req(hlik_pkg::MODE_POSE, 0, 0, P_ONE, -P_ONE, 0,
                         S32_MIN, S32_MAX, S32_MIN, S32_MAX), 1'b0);
        add_row(make_req(hlik_pkg::MODE_POSE, 0, 0, 0, 0, 0,
                         S32_MAX, S32_MAX, S32_MAX, S32_MAX), 1'b0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) send_req(directed_rows[i]);

        sent = 0;
        while (sent < RANDOM_REQS) begin
            // idle profile: sender light and receiver heavy, then swapped, then none
            if (sent == RANDOM_REQS / 3) begin
                send_idle_pct = 78;
                recv_stall_pct = 28;
            end else if (sent == 2 * RANDOM_REQS / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            // hold off once until every outstanding leg has come back
            if (sent == RANDOM_REQS / 2) begin
                s_valid <= 1'b0;
                while (pending_legs.size() != 0) @(posedge aclk);
            end
            d.req = rand_req();
            d.all_degenerate = 1'b0;
            send_req(d);
            sent++;
        end
        s_valid <= 1'b0;

        while (pending_legs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_legs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, well beyond the slowest correct run
    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
